// ----- rtl/core/paired_pulse_stretcher_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the pulse stretcher RTL
// ---------------------------------------------------------------------------
`ifndef PAIRED_PULSE_STRETCHER_MACROS_SVH
`define PAIRED_PULSE_STRETCHER_MACROS_SVH

// Same-cycle implication on i_clk, disabled while i_rst_n is low.
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled while i_rst_n is low.
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pps_pkg.sv -----
// ---------------------------------------------------------------------------
// pps_pkg
// Shared widths, register indexes and the per-pair result type.
// ---------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int TIME_W     = 32;
    localparam int FLAG_W     = 8;
    localparam int PAIR_W     = 2;
    localparam int MAX_PAIRS  = FLAG_W / PAIR_W;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD = 8'd1;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd80;

    typedef struct packed {
        logic [PAIR_W-1:0] held;
        logic              dl_wr;
        logic [TIME_W-1:0] dl_value;
    } t_pair_result;

endpackage

`default_nettype wire

// ----- rtl/core/pps_pair.sv -----
// ---------------------------------------------------------------------------
// pps_pair
// Next held bits and deadline update for one direction pair.
// ---------------------------------------------------------------------------
`default_nettype none

module pps_pair
    import pps_pkg::*;
(
    input  wire logic              i_tracked,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic [HOLD_W-1:0] i_hold,
    input  wire logic [PAIR_W-1:0] i_cur,
    input  wire logic [PAIR_W-1:0] i_ret,
    input  wire logic [TIME_W-1:0] i_deadline,
    output t_pair_result           o_res
);

    logic [PAIR_W-1:0] w_merged;
    logic [TIME_W-1:0] w_deadline;
    logic [TIME_W-1:0] w_diff;
    logic              w_hit;

    always_comb begin
        w_hit    = (i_cur != '0);
        // merge, then resolve a both-directions conflict with the current bits
        w_merged = i_tracked ? (i_ret | i_cur) : '0;
        if (w_merged == '1) begin
            w_merged = i_cur;
        end
        w_deadline = w_hit ? (i_now + {{(TIME_W-HOLD_W){1'b0}}, i_hold}) : i_deadline;
        w_diff     = i_now - w_deadline;
        // drop the pair once now has reached the deadline (signed compare)
        if (!w_diff[TIME_W-1]) begin
            w_merged = '0;
        end
        o_res.held     = w_merged;
        o_res.dl_wr    = i_tracked && w_hit;
        o_res.dl_value = w_deadline;
    end

endmodule

`default_nettype wire

// ----- rtl/core/paired_pulse_stretcher.sv -----
// ---------------------------------------------------------------------------
// paired_pulse_stretcher
// Flow: a transaction loads into the input register at acceptance and moves
// on into the result register once that is free. Throughput: one
// transaction per cycle while the output is not stalled; the pair update is
// a single pass of one 32-bit add and one 32-bit subtract per pair.
// Reset (synchronous, active low) clears held flags, deadlines, valids and
// restores three-pair mode with an 80 ms hold time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "paired_pulse_stretcher_macros.svh"

module paired_pulse_stretcher
    import pps_pkg::*;
#(
    parameter int NUM_PAIRS = 4
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [TIME_W-1:0]     i_now_time,
    input  wire logic [FLAG_W-1:0]     i_pulse_flags,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [FLAG_W-1:0]          o_held_flags,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic              r_four_pair_mode;
    logic [HOLD_W-1:0] r_hold_time;

    // Input register stage
    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_now;
    logic [FLAG_W-1:0] r_in_flags;

    // Result register stage
    logic              r_out_valid;
    logic [FLAG_W-1:0] r_out_held;

    // Pulse state
    logic [FLAG_W-1:0] r_retained;
    logic [FLAG_W-1:0] n_retained;
    logic [TIME_W-1:0] r_deadline [NUM_PAIRS];

    logic         w_in_accept;
    logic         w_out_free;
    logic         w_load_out;
    t_pair_result w_pair [NUM_PAIRS];

    // The result register can take a new transaction when it is empty or
    // being drained this cycle. Stall the input only when the input register
    // holds a transaction that cannot move on.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_held_flags = r_out_held;

    // Configuration writes land at once; keep the block idle around them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_pair_mode <= 1'b0;
            r_hold_time      <= HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDX_MODE: r_four_pair_mode <= i_cfg_data[0];
                CFG_IDX_HOLD: r_hold_time      <= i_cfg_data[HOLD_W-1:0];
                default: ;  // unknown index: ignore the write
            endcase
        end
    end

    // Input register: hold while stalled, advance on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_load_out) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_now   <= i_now_time;
            r_in_flags <= i_pulse_flags;
        end
    end

    // Per-pair evaluation. The last pair is tracked only in four-pair mode;
    // all pairs run in parallel since each touches only its own bits.
    for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
        pps_pair u_pair (
            .i_tracked  ((p < NUM_PAIRS - 1) ? 1'b1 : r_four_pair_mode),
            .i_now      (r_in_now),
            .i_hold     (r_hold_time),
            .i_cur      (r_in_flags[PAIR_W*p +: PAIR_W]),
            .i_ret      (r_retained[PAIR_W*p +: PAIR_W]),
            .i_deadline (r_deadline[p]),
            .o_res      (w_pair[p])
        );
    end

    // Gather pair results; bits beyond the configured pair count stay zero.
    always_comb begin
        n_retained = '0;
        for (int p = 0; p < NUM_PAIRS; p++) begin
            n_retained[PAIR_W*p +: PAIR_W] = w_pair[p].held;
        end
    end

    // State and result update happen together when a transaction moves into
    // the result register, so the next transaction always sees fresh state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retained <= '0;
            for (int p = 0; p < NUM_PAIRS; p++) begin
                r_deadline[p] <= '0;
            end
        end else if (w_load_out) begin
            r_retained <= n_retained;
            for (int p = 0; p < NUM_PAIRS; p++) begin
                if (w_pair[p].dl_wr) begin
                    r_deadline[p] <= w_pair[p].dl_value;
                end
            end
        end
    end

    // Result register: load on advance, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_held <= n_retained;
        end
    end

    // A pending result always mirrors the retained state it produced.
    `PPS_ASSERT_IMP(a_out_matches_state, r_out_valid, o_held_flags == r_retained, "held != state")
    // The input side stalls only with a transaction waiting in the input register.
    `PPS_ASSERT_IMP(a_stall_needs_item, o_in_stall, r_in_valid, "stall with empty input register")
    // A transaction moved forward must show up as a valid result.
    `PPS_ASSERT_NXT(a_load_shows_result, w_load_out, o_out_valid, "advanced result missing")

endmodule

`default_nettype wire
